/* rtl/complex_arithmetic_unit_core_macros.svh */
// Assertion macros for the complex arithmetic unit.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Check on every clock edge outside reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/cau_pkg.sv */
// Shared constants for the complex arithmetic unit: default widths, opcodes.
// No dependencies.
package cau_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned FracBits  = 16;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ  = 4'd4;
  localparam logic [3:0] OP_NE  = 4'd5;
  localparam logic [3:0] OP_GE  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_LT  = 4'd9;

endpackage

/* rtl/cau_div.sv */
// Pipelined restoring divider, one quotient bit per stage, WORD_WIDTH stages.
// Depends on cau_pkg for default widths. Caller guarantees num_hi_i < den_i.
module cau_div #(
  parameter int unsigned WORD_WIDTH = cau_pkg::WordWidth,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBits
) (
  input  logic                             clk_i,
  input  logic [WORD_WIDTH+FRAC_BITS:0]    num_hi_i,
  input  logic [WORD_WIDTH-1:0]            num_lo_i,
  input  logic [2*WORD_WIDTH:0]            den_i,
  output logic [WORD_WIDTH-1:0]            quot_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned HW = WORD_WIDTH + FRAC_BITS + 1;
  localparam int unsigned DW = 2 * WORD_WIDTH + 1;
  localparam int unsigned RW = (HW > DW) ? HW : DW;

  logic [RW-1:0] rem_q  [W];
  logic [RW-1:0] den_q  [W];
  logic [W-1:0]  lo_q   [W];
  logic [W-1:0]  quot_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0] rem_in, den_in;
    logic [W-1:0]  lo_in, quot_in;
    logic [RW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = RW'(num_hi_i);
      assign den_in  = RW'(den_i);
      assign lo_in   = num_lo_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign rem_sh = {rem_in, lo_in[W-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RW'(rem_sh - {1'b0, den_in}) : rem_sh[RW-1:0];
      den_q[k]  <= den_in;
      lo_q[k]   <= {lo_in[W-2:0], 1'b0};
      quot_q[k] <= {quot_in[W-2:0], ge};
    end
  end

  assign quot_o = quot_q[W-1];

endmodule

/* rtl/complex_arithmetic_unit_core.sv */
// Complex arithmetic unit: top level, add/sub/mul/div/compare on Q-format words.
// Depends on cau_pkg, cau_div and complex_arithmetic_unit_core_macros.svh.
// Fully pipelined: busy is high through reset and for the first clock after it, then
// stays low, so a word may be started on every clock. Every word, whatever the opcode,
// passes through stage 1, stage 2, stage 3, the divider stages, which resolve one
// quotient bit per stage, and the output stage, whose done_o strobe and results are
// registered together. The receiver cannot stall, so results are shown for one
// cycle only.
`include "complex_arithmetic_unit_core_macros.svh"

module complex_arithmetic_unit_core #(
  parameter int unsigned WORD_WIDTH = cau_pkg::WordWidth,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   op_i,
  input  logic signed [WORD_WIDTH-1:0] a_re_i,
  input  logic signed [WORD_WIDTH-1:0] a_im_i,
  input  logic signed [WORD_WIDTH-1:0] b_re_i,
  input  logic signed [WORD_WIDTH-1:0] b_im_i,
  output logic                         done_o,
  output logic signed [WORD_WIDTH-1:0] res_re_o,
  output logic signed [WORD_WIDTH-1:0] res_im_o,
  output logic                         cmp_true_o,
  output logic                         overflow_o,
  output logic                         div_zero_o
);

  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned S   = 2 * WORD_WIDTH + 1;
  localparam int unsigned M   = S + FRAC_BITS;
  localparam int unsigned CW  = (S > M - W) ? S : M - W;
  localparam int unsigned LAT = WORD_WIDTH + 4;

  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MaxNeg = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic         valid;
    logic [3:0]   op;
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         ovf;
    logic         cmp;
    logic         dz;
    logic         neg_re;
    logic         neg_im;
    logic         big_re;
    logic         big_im;
  } side_t;

  function automatic logic [W:0] sat_word(input logic signed [S-1:0] x);
    logic [W:0] r;
    if (x > $signed({{(S-W+1){1'b0}}, {(W-1){1'b1}}})) begin
      r = {1'b1, MaxPos};
    end else if (x < $signed({{(S-W+1){1'b1}}, {(W-1){1'b0}}})) begin
      r = {1'b1, MaxNeg};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic signed [S-1:0] trunc_frac(input logic signed [S-1:0] x);
    logic signed [S-1:0] bias;
    bias = x[S-1] ? S'((65'd1 << FRAC_BITS) - 65'd1) : '0;
    return (x + bias) >>> FRAC_BITS;
  endfunction

  function automatic logic [W:0] sat_quot(input logic [W-1:0] q, input logic neg,
                                          input logic big);
    logic [W-1:0] lim;
    logic [W-1:0] m;
    logic         o;
    lim = neg ? MaxNeg : MaxPos;
    o   = big || (q > lim);
    m   = o ? lim : q;
    return {o, neg ? W'(-m) : m};
  endfunction

  // reset state and input stage
  logic busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end
  assign busy = busy_q;

  // stage 1: products, sums, equality
  logic                v1_q;
  logic [3:0]          op1_q;
  logic signed [2*W-1:0] prr_q, pii_q, pir_q, pri_q, paa_q, pab_q, pba_q, pbb_q;
  logic signed [W:0]   sre1_q, sim1_q;
  logic                eq1_q;
  logic signed [W:0]   are_x, aim_x, bre_x, bim_x;

  assign are_x = a_re_i;
  assign aim_x = a_im_i;
  assign bre_x = b_re_i;
  assign bim_x = b_im_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= op_i;
    prr_q  <= a_re_i * b_re_i;
    pii_q  <= a_im_i * b_im_i;
    pir_q  <= a_im_i * b_re_i;
    pri_q  <= a_re_i * b_im_i;
    paa_q  <= a_re_i * a_re_i;
    pab_q  <= a_im_i * a_im_i;
    pba_q  <= b_re_i * b_re_i;
    pbb_q  <= b_im_i * b_im_i;
    sre1_q <= (op_i == cau_pkg::OP_SUB) ? are_x - bre_x : are_x + bre_x;
    sim1_q <= (op_i == cau_pkg::OP_SUB) ? aim_x - bim_x : aim_x + bim_x;
    eq1_q  <= (a_re_i == b_re_i) && (a_im_i == b_im_i);
  end

  // stage 2: cross sums and squared norms
  logic                v2_q;
  logic [3:0]          op2_q;
  logic signed [S-1:0] re2_q, im2_q;
  logic [S-1:0]        na2_q, nb2_q;
  logic signed [W:0]   sre2_q, sim2_q;
  logic                eq2_q;
  logic signed [S-1:0] prr_x, pii_x, pir_x, pri_x;

  assign prr_x = prr_q;
  assign pii_x = pii_q;
  assign pir_x = pir_q;
  assign pri_x = pri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q  <= op1_q;
    re2_q  <= (op1_q == cau_pkg::OP_DIV) ? prr_x + pii_x : prr_x - pii_x;
    im2_q  <= (op1_q == cau_pkg::OP_DIV) ? pir_x - pri_x : pir_x + pri_x;
    na2_q  <= {1'b0, paa_q} + {1'b0, pab_q};
    nb2_q  <= {1'b0, pba_q} + {1'b0, pbb_q};
    sre2_q <= sre1_q;
    sim2_q <= sim1_q;
    eq2_q  <= eq1_q;
  end

  // stage 3: saturation, compares, divider set-up
  side_t        side3_d, side3_q;
  logic [S-1:0] mag_re, mag_im;
  logic [M-1:0] num_re, num_im;
  logic [W:0]   sat_re, sat_im;
  logic [M-W-1:0] hi_re_q, hi_im_q;
  logic [W-1:0] lo_re_q, lo_im_q;
  logic [S-1:0] den_q;

  assign mag_re = re2_q[S-1] ? S'(-re2_q) : re2_q;
  assign mag_im = im2_q[S-1] ? S'(-im2_q) : im2_q;
  assign num_re = {mag_re, {FRAC_BITS{1'b0}}};
  assign num_im = {mag_im, {FRAC_BITS{1'b0}}};

  always_comb begin
    side3_d        = '0;
    side3_d.valid  = v2_q;
    side3_d.op     = op2_q;
    side3_d.neg_re = re2_q[S-1];
    side3_d.neg_im = im2_q[S-1];
    side3_d.big_re = CW'(num_re[M-1:W]) >= CW'(nb2_q);
    side3_d.big_im = CW'(num_im[M-1:W]) >= CW'(nb2_q);
    side3_d.dz     = nb2_q == '0;
    sat_re         = '0;
    sat_im         = '0;
    case (op2_q)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        sat_re = sat_word(S'(sre2_q));
        sat_im = sat_word(S'(sim2_q));
      end
      cau_pkg::OP_MUL: begin
        sat_re = sat_word(trunc_frac(re2_q));
        sat_im = sat_word(trunc_frac(im2_q));
      end
      cau_pkg::OP_EQ: side3_d.cmp = eq2_q;
      cau_pkg::OP_NE: side3_d.cmp = !eq2_q;
      cau_pkg::OP_GE: side3_d.cmp = na2_q >= nb2_q;
      cau_pkg::OP_LE: side3_d.cmp = na2_q <= nb2_q;
      cau_pkg::OP_GT: side3_d.cmp = na2_q > nb2_q;
      cau_pkg::OP_LT: side3_d.cmp = na2_q < nb2_q;
      default: ;
    endcase
    side3_d.re  = sat_re[W-1:0];
    side3_d.im  = sat_im[W-1:0];
    side3_d.ovf = sat_re[W] || sat_im[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_q <= '0;
    end else begin
      side3_q <= side3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_re_q        <= num_re[M-1:W];
    hi_im_q        <= num_im[M-1:W];
    lo_re_q        <= num_re[W-1:0];
    lo_im_q        <= num_im[W-1:0];
    den_q          <= nb2_q;
  end

  // divider stages, side word delayed alongside
  logic [W-1:0] quot_re, quot_im;
  side_t        side_q [W];

  cau_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk_i    (clk_i),
    .num_hi_i (hi_re_q),
    .num_lo_i (lo_re_q),
    .den_i    (den_q),
    .quot_o   (quot_re)
  );

  cau_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk_i    (clk_i),
    .num_hi_i (hi_im_q),
    .num_lo_i (lo_im_q),
    .den_i    (den_q),
    .quot_o   (quot_im)
  );

  for (genvar k = 0; k < W; k++) begin : g_side
    side_t prev;
    if (k == 0) begin : g_first
      assign prev = side3_q;
    end else begin : g_next
      assign prev = side_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else begin
        side_q[k] <= prev;
      end
    end
  end

  // output stage
  side_t        sl;
  logic [W:0]   q_re, q_im;
  logic [W-1:0] res_re_d, res_im_d;
  logic         cmp_d, ovf_d, dz_d;
  logic         done_q;
  logic [W-1:0] res_re_q, res_im_q;
  logic         cmp_q, ovf_q, dz_q;

  assign sl   = side_q[W-1];
  assign q_re = sat_quot(quot_re, sl.neg_re, sl.big_re);
  assign q_im = sat_quot(quot_im, sl.neg_im, sl.big_im);

  always_comb begin
    res_re_d = sl.re;
    res_im_d = sl.im;
    ovf_d    = sl.ovf;
    cmp_d    = sl.cmp;
    dz_d     = 1'b0;
    if (sl.op == cau_pkg::OP_DIV) begin
      if (sl.dz) begin
        res_re_d = '0;
        res_im_d = '0;
        ovf_d    = 1'b0;
        dz_d     = 1'b1;
      end else begin
        res_re_d = q_re[W-1:0];
        res_im_d = q_im[W-1:0];
        ovf_d    = q_re[W] || q_im[W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    cmp_q    <= cmp_d;
    ovf_q    <= ovf_d;
    dz_q     <= dz_d;
  end

  assign done_o     = done_q;
  assign res_re_o   = res_re_q;
  assign res_im_o   = res_im_q;
  assign cmp_true_o = cmp_q;
  assign overflow_o = ovf_q;
  assign div_zero_o = dz_q;

  `CAU_ASSERT(a_fixed_latency, (start && !busy) |-> ##LAT done_o, "word lost in pipeline")
  `CAU_ASSERT(a_dz_clean, (done_o && div_zero_o) |-> (res_re_o == '0 && res_im_o == '0 && !overflow_o && !cmp_true_o), "divide by zero word not cleared")
  `CAU_ASSERT(a_cmp_clean, (done_o && cmp_true_o) |-> (res_re_o == '0 && res_im_o == '0 && !overflow_o), "compare word carries arithmetic data")
  `CAU_ASSERT(a_ovf_sat, (done_o && overflow_o) |-> (res_re_o == MaxPos || res_re_o == MaxNeg || res_im_o == MaxPos || res_im_o == MaxNeg), "overflow without saturated part")
  `CAU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o, "strobe during reset")

endmodule
